/* hw/rtl/fpa_pkg.sv */
package fpa_pkg;

  // Format of the raw operands
  localparam int FRAC_BITS  = 8;
  localparam int DATA_WIDTH = 32;
  // Numerator width of the divider: |a| shifted up by the fraction bits
  localparam int NUM_W      = DATA_WIDTH + FRAC_BITS;

  // Opcodes
  localparam logic [3:0] OP_ADD     = 4'd0;
  localparam logic [3:0] OP_SUB     = 4'd1;
  localparam logic [3:0] OP_MUL     = 4'd2;
  localparam logic [3:0] OP_DIV     = 4'd3;
  localparam logic [3:0] OP_GT      = 4'd4;
  localparam logic [3:0] OP_LT      = 4'd5;
  localparam logic [3:0] OP_GE      = 4'd6;
  localparam logic [3:0] OP_LE      = 4'd7;
  localparam logic [3:0] OP_EQ      = 4'd8;
  localparam logic [3:0] OP_NE      = 4'd9;
  localparam logic [3:0] OP_MIN     = 4'd10;
  localparam logic [3:0] OP_MAX     = 4'd11;
  localparam logic [3:0] OP_INC     = 4'd12;
  localparam logic [3:0] OP_DEC     = 4'd13;
  localparam logic [3:0] OP_TOINT   = 4'd14;
  localparam logic [3:0] OP_FROMINT = 4'd15;

  // Status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  // Saturation limits
  localparam logic [DATA_WIDTH-1:0] MAX_V = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] MIN_V = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic [3:0]         func;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               compare_true;
    logic [1:0]         status;
  } out_t;

  // Transaction data carried alongside the divider
  typedef struct packed {
    out_t res;
    logic is_div;
    logic neg;
    logic div0;
  } side_t;

  // Sign-extend a data-width value to the 32-bit port field
  function automatic logic signed [31:0] sext(input logic [DATA_WIDTH-1:0] v);
    sext = 32'(signed'(v));
  endfunction

endpackage

/* hw/rtl/fpa_div.sv */
module fpa_div import fpa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  side_t                 in_side,
  input  logic [NUM_W-1:0]      in_num,
  input  logic [DATA_WIDTH-1:0] in_den,
  output logic                  out_valid,
  output side_t                 out_side,
  output logic [NUM_W-1:0]      out_quo,
  output logic [DATA_WIDTH-1:0] out_rem,
  output logic [DATA_WIDTH-1:0] out_den
);

  // One restoring step per stage; nq holds the unused numerator bits
  // shifting out at the top and quotient bits shifting in at the bottom.
  logic                  v_q   [0:NUM_W-1];
  side_t                 sd_q  [0:NUM_W-1];
  logic [NUM_W-1:0]      nq_q  [0:NUM_W-1];
  logic [DATA_WIDTH-1:0] rem_q [0:NUM_W-1];
  logic [DATA_WIDTH-1:0] den_q [0:NUM_W-1];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic                  v_src;
    side_t                 sd_src;
    logic [NUM_W-1:0]      nq_src;
    logic [DATA_WIDTH-1:0] rem_src;
    logic [DATA_WIDTH-1:0] den_src;
    logic [DATA_WIDTH:0]   trial;
    logic [DATA_WIDTH:0]   diff;
    logic                  ge;

    if (k == 0) begin : g_first
      assign v_src   = in_valid;
      assign sd_src  = in_side;
      assign nq_src  = in_num;
      assign rem_src = '0;
      assign den_src = in_den;
    end else begin : g_next
      assign v_src   = v_q[k-1];
      assign sd_src  = sd_q[k-1];
      assign nq_src  = nq_q[k-1];
      assign rem_src = rem_q[k-1];
      assign den_src = den_q[k-1];
    end

    // trial subtract of the divisor
    assign trial = {rem_src, nq_src[NUM_W-1]};
    assign ge    = trial >= {1'b0, den_src};
    assign diff  = trial - {1'b0, den_src};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else if (en) begin
        v_q[k] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd_q[k]  <= sd_src;
        den_q[k] <= den_src;
        nq_q[k]  <= {nq_src[NUM_W-2:0], ge};
        rem_q[k] <= ge ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
      end
    end
  end

  assign out_valid = v_q[NUM_W-1];
  assign out_side  = sd_q[NUM_W-1];
  assign out_quo   = nq_q[NUM_W-1];
  assign out_rem   = rem_q[NUM_W-1];
  assign out_den   = den_q[NUM_W-1];

endmodule

/* hw/rtl/fixed_point_alu_q24_8_unit.sv */
// Signed fixed-point ALU, saturating, round half away from zero.
// Operands are 24.8; every opcode passes the stage 1, 2 and 3 registers, the
// divider stages and the output register; the bit-per-stage divider sets the depth.
// Throughput: one transaction per cycle; a stall freezes the whole pipeline.
// Reset (rst, synchronous) empties the pipeline; no other state.
module fixed_point_alu_q24_8_unit import fpa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int PW = 2 * DATA_WIDTH;

  logic en;
  logic div_valid;
  side_t div_side;
  logic [NUM_W-1:0] div_quo;
  logic [DATA_WIDTH-1:0] div_rem;
  logic [DATA_WIDTH-1:0] div_den;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Stage 1: capture operands
  logic                         v1;
  logic [3:0]                   f1;
  logic signed [DATA_WIDTH-1:0] a1, b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1 <= in_data.func;
      a1 <= in_data.operand_a[DATA_WIDTH-1:0];
      b1 <= in_data.operand_b[DATA_WIDTH-1:0];
    end
  end

  // Stage 2: simple ops, product, divider operand set-up
  logic [DATA_WIDTH:0]   sum_w, dif_w, inc_w, dec_w;
  logic                  lt_w, gt_w, eq_w;
  logic [DATA_WIDTH-1:0] toint_w, fromint_w;
  logic                  fi_ovf;
  out_t                  simple_w;

  assign sum_w = {a1[DATA_WIDTH-1], a1} + {b1[DATA_WIDTH-1], b1};
  assign dif_w = {a1[DATA_WIDTH-1], a1} - {b1[DATA_WIDTH-1], b1};
  assign inc_w = {a1[DATA_WIDTH-1], a1} + (DATA_WIDTH+1)'(1);
  assign dec_w = {a1[DATA_WIDTH-1], a1} - (DATA_WIDTH+1)'(1);
  assign lt_w  = a1 < b1;
  assign gt_w  = a1 > b1;
  assign eq_w  = a1 == b1;
  assign toint_w   = DATA_WIDTH'(a1 >>> FRAC_BITS);
  assign fromint_w = DATA_WIDTH'(a1 <<< FRAC_BITS);
  // top FRAC_BITS+1 bits must all match the sign for the shift to fit
  assign fi_ovf = !((&a1[DATA_WIDTH-1:DATA_WIDTH-1-FRAC_BITS]) ||
                    !(|a1[DATA_WIDTH-1:DATA_WIDTH-1-FRAC_BITS]));

  function automatic void sat33(input logic [DATA_WIDTH:0] s,
                                output logic [DATA_WIDTH-1:0] r,
                                output logic [1:0] st);
    if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
      r  = s[DATA_WIDTH] ? MIN_V : MAX_V;
      st = ST_OVF;
    end else begin
      r  = s[DATA_WIDTH-1:0];
      st = ST_OK;
    end
  endfunction

  always_comb begin
    logic [DATA_WIDTH-1:0] r;
    logic [1:0]            st;
    logic                  c;
    r  = '0;
    st = ST_OK;
    c  = 1'b0;
    unique case (f1)
      OP_ADD:     sat33(sum_w, r, st);
      OP_SUB:     sat33(dif_w, r, st);
      OP_INC:     sat33(inc_w, r, st);
      OP_DEC:     sat33(dec_w, r, st);
      OP_GT:      c = gt_w;
      OP_LT:      c = lt_w;
      OP_GE:      c = !lt_w;
      OP_LE:      c = !gt_w;
      OP_EQ:      c = eq_w;
      OP_NE:      c = !eq_w;
      OP_MIN:     r = lt_w ? a1 : b1;
      OP_MAX:     r = gt_w ? a1 : b1;
      OP_TOINT:   r = toint_w;
      OP_FROMINT: begin
        if (fi_ovf) begin
          r  = a1[DATA_WIDTH-1] ? MIN_V : MAX_V;
          st = ST_OVF;
        end else begin
          r = fromint_w;
        end
      end
      default: ;  // mul and div finish later
    endcase
    simple_w.result_value = sext(r);
    simple_w.compare_true = c;
    simple_w.status       = st;
  end

  logic                  v2;
  logic [3:0]            f2;
  out_t                  simple2;
  logic signed [PW-1:0]  p2;
  logic [NUM_W-1:0]      n2;
  logic [DATA_WIDTH-1:0] d2;
  logic                  neg2, div0_2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2      <= f1;
      simple2 <= simple_w;
      p2      <= PW'(a1) * PW'(b1);
      n2      <= NUM_W'(a1[DATA_WIDTH-1] ? -a1 : a1) << FRAC_BITS;
      d2      <= b1[DATA_WIDTH-1] ? DATA_WIDTH'(-b1) : DATA_WIDTH'(b1);
      neg2    <= a1[DATA_WIDTH-1] ^ b1[DATA_WIDTH-1];
      div0_2  <= b1 == '0;
    end
  end

  // Stage 3: round and saturate the product
  logic [PW-1:0] pm, pq, plim;
  logic          pneg;
  out_t          res3_w;

  assign pneg = p2[PW-1];
  assign pm   = pneg ? PW'(-p2) : PW'(p2);
  assign pq   = (pm + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
  assign plim = (PW'(1) << (DATA_WIDTH - 1)) - PW'(!pneg);

  always_comb begin
    res3_w = simple2;
    if (f2 == OP_MUL) begin
      res3_w.compare_true = 1'b0;
      if (pq > plim) begin
        res3_w.result_value = sext(pneg ? MIN_V : MAX_V);
        res3_w.status       = ST_OVF;
      end else begin
        res3_w.result_value = sext(pneg ? DATA_WIDTH'(-pq) : DATA_WIDTH'(pq));
        res3_w.status       = ST_OK;
      end
    end
  end

  logic                  v3;
  side_t                 side3;
  logic [NUM_W-1:0]      n3;
  logic [DATA_WIDTH-1:0] d3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side3.res    <= res3_w;
      side3.is_div <= f2 == OP_DIV;
      side3.neg    <= neg2;
      side3.div0   <= div0_2;
      n3           <= n2;
      d3           <= d2;
    end
  end

  // Divider stages; other opcodes ride along in the side data
  fpa_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v3),
    .in_side   (side3),
    .in_num    (n3),
    .in_den    (d3),
    .out_valid (div_valid),
    .out_side  (div_side),
    .out_quo   (div_quo),
    .out_rem   (div_rem),
    .out_den   (div_den)
  );

  // Final stage: round the quotient, apply sign, saturate; a zero divisor gives 0 and ST_DIV0
  logic [NUM_W:0] qf, qlim;
  logic           rnd;
  out_t           fin_w;

  assign rnd  = {div_rem, 1'b0} >= {1'b0, div_den};
  assign qf   = {1'b0, div_quo} + (NUM_W+1)'(rnd);
  assign qlim = ((NUM_W+1)'(1) << (DATA_WIDTH - 1)) - (NUM_W+1)'(!div_side.neg);

  always_comb begin
    fin_w = div_side.res;
    if (div_side.is_div) begin
      fin_w.compare_true = 1'b0;
      if (div_side.div0) begin
        fin_w.result_value = '0;
        fin_w.status       = ST_DIV0;
      end else if (qf > qlim) begin
        fin_w.result_value = sext(div_side.neg ? MIN_V : MAX_V);
        fin_w.status       = ST_OVF;
      end else begin
        fin_w.result_value = sext(div_side.neg ? DATA_WIDTH'(-qf) : DATA_WIDTH'(qf));
        fin_w.status       = ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= fin_w;
    end
  end

endmodule
